[src/mbrc_pkg.sv]
// ----------------------------------------------------------------------------
// mbrc_pkg
// Types, codes and the byte-wise CRC-16 step shared by the response checker.
// ----------------------------------------------------------------------------
package mbrc_pkg;

	localparam int unsigned FRAME_BYTES = 9;

	localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
	localparam logic [15:0] CRC_POLY          = 16'hA001;
	localparam logic [15:0] CRC_INIT          = 16'hFFFF;
	localparam logic [3:0]  INDEX_MAX         = 4'd15;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_ADDR = 3'd1;
	localparam logic [2:0] ST_BAD_FUNC = 3'd2;
	localparam logic [2:0] ST_BAD_LEN  = 3'd3;
	localparam logic [2:0] ST_BAD_CRC  = 3'd4;

	localparam logic [1:0] FAULT_NONE = 2'd0;
	localparam logic [1:0] FAULT_ADDR = 2'd1;
	localparam logic [1:0] FAULT_FUNC = 2'd2;

	typedef struct packed {
		logic [3:0]  byte_index;
		logic [15:0] crc_running;
		logic [1:0]  header_fault;
		logic [31:0] value_shift;
	} chan_state_t;

	localparam chan_state_t STATE_CLEAR = '{
		byte_index:   4'd0,
		crc_running:  CRC_INIT,
		header_fault: FAULT_NONE,
		value_shift:  32'd0
	};

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
		logic [7:0] slave_address;
	} step_in_t;

	typedef struct packed {
		logic [2:0] frame_status;
		logic [31:0] count_value;
	} step_res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[src/modbus_read_response_check.sv]
// ----------------------------------------------------------------------------
// modbus_read_response_check
// Multi-channel Modbus RTU read-holding-register response checker.
// ----------------------------------------------------------------------------
// channel  | direction | handshake          | payload
// input    | in        | in_valid/in_stall  | channel, rx_byte, frame_end
// result   | out       | out_valid/out_stall| out_channel, frame_status, count_value
// config   | in        | cfg_valid/cfg_ready| cfg_data (slave address)
//
// One byte per cycle unless stalled; results pass stage 1 and the output register.
// State is read from the channel store on transfer, updated and written back
// from stage 1; a back-to-back byte on the same channel takes the forwarded state.
// Channel state resets through per-entry valid bits, cleared at once by arst_n.
// Input stalls only while a result is held in the output register and stalled.
// ----------------------------------------------------------------------------
module modbus_read_response_check
	import mbrc_pkg::*;
#(
	parameter int unsigned CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  channel,
	input  logic [7:0]  rx_byte,
	input  logic        frame_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  out_channel,
	output logic [2:0]  frame_status,
	output logic signed [31:0] count_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam int unsigned ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [7:0]          slave_address_q;
	logic [CHANNELS-1:0] valid_q;

	logic                v_s1;
	logic [1:0]          chan_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic                in_range_s1;
	logic [7:0]          byte_s1;
	logic                end_s1;
	logic                hit_s1;

	chan_state_t         fwd_q;
	chan_state_t         rd_data;
	chan_state_t         cur;
	chan_state_t         nxt;
	step_in_t            din;
	step_res_t           res;

	logic                out_valid_q;
	logic [1:0]          out_channel_q;
	logic [2:0]          frame_status_q;
	logic [31:0]         count_value_q;

	logic [31:0]         chan_ext;
	logic [ADDR_W-1:0]   in_addr;
	logic                in_range;
	logic                accept;
	logic                s1_go;
	logic                wr_en;

	assign chan_ext = 32'(channel);
	assign in_addr  = chan_ext[ADDR_W-1:0];
	assign in_range = chan_ext < CHANNELS;

	assign s1_go    = v_s1 && (!out_valid_q || !out_stall);
	assign in_stall = v_s1 && !s1_go;
	assign accept   = in_valid && !in_stall;
	assign wr_en    = s1_go && in_range_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= 8'h01;
		end else if (cfg_valid && cfg_ready) begin
			slave_address_q <= cfg_data;
		end
	end

	mbrc_state_ram #(
		.DEPTH  (CHANNELS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (in_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_s1),
		.wr_data (nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chan_s1     <= channel;
			addr_s1     <= in_addr;
			in_range_s1 <= in_range;
			byte_s1     <= rx_byte;
			end_s1      <= frame_end;
			hit_s1      <= wr_en && (addr_s1 == in_addr);
		end
		if (wr_en) begin
			fwd_q <= nxt;
		end
	end

	always_comb begin
		if (!in_range_s1 || !valid_q[addr_s1]) begin
			cur = STATE_CLEAR;
		end else if (hit_s1) begin
			cur = fwd_q;
		end else begin
			cur = rd_data;
		end
		din.rx_byte       = byte_s1;
		din.frame_end     = end_s1;
		din.slave_address = slave_address_q;
	end

	mbrc_frame_step u_step (
		.cur (cur),
		.din (din),
		.nxt (nxt),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[addr_s1] <= !end_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && end_s1) begin
			out_channel_q  <= chan_s1;
			frame_status_q <= res.frame_status;
			count_value_q  <= res.count_value;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_channel  = out_channel_q;
	assign frame_status = frame_status_q;
	assign count_value  = $signed(count_value_q);

endmodule

[src/mbrc_state_ram.sv]
// ----------------------------------------------------------------------------
// mbrc_state_ram
// Per-channel state store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mbrc_state_ram
	import mbrc_pkg::*;
#(
	parameter int unsigned DEPTH  = 4,
	parameter int unsigned ADDR_W = 2
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output chan_state_t       rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  chan_state_t       wr_data
);

	chan_state_t mem [DEPTH];
	chan_state_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/mbrc_frame_step.sv]
// ----------------------------------------------------------------------------
// mbrc_frame_step
// Applies one received byte to a channel's state and forms the frame status.
// ----------------------------------------------------------------------------
module mbrc_frame_step
	import mbrc_pkg::*;
(
	input  chan_state_t cur,
	input  step_in_t    din,
	output chan_state_t nxt,
	output step_res_t   res
);

	chan_state_t upd;
	logic [4:0]  idx_ext;

	always_comb begin
		upd     = cur;
		idx_ext = {1'b0, cur.byte_index} + 5'd2;
		if (cur.byte_index == 4'd0 && din.rx_byte != din.slave_address
				&& cur.header_fault == FAULT_NONE) begin
			upd.header_fault = FAULT_ADDR;
		end
		if (cur.byte_index == 4'd1 && din.rx_byte != FUNC_READ_HOLDING
				&& cur.header_fault == FAULT_NONE) begin
			upd.header_fault = FAULT_FUNC;
		end
		if (cur.byte_index >= 4'd3 && idx_ext < 5'(FRAME_BYTES)) begin
			upd.value_shift = {cur.value_shift[23:0], din.rx_byte};
		end
		upd.crc_running = crc_byte(cur.crc_running, din.rx_byte);
		if (cur.byte_index < INDEX_MAX) begin
			upd.byte_index = cur.byte_index + 4'd1;
		end

		if (upd.header_fault != FAULT_NONE) begin
			res.frame_status = {1'b0, upd.header_fault};
		end else if (cur.byte_index != 4'(FRAME_BYTES - 1)) begin
			res.frame_status = ST_BAD_LEN;
		end else if (upd.crc_running != 16'd0) begin
			res.frame_status = ST_BAD_CRC;
		end else begin
			res.frame_status = ST_OK;
		end
		res.count_value = upd.value_shift;

		nxt = din.frame_end ? STATE_CLEAR : upd;
	end

endmodule

[src/mbrc_checker.sv]
// ----------------------------------------------------------------------------
// mbrc_checker
// Port-level checks on the response checker, bound to the top level.
// ----------------------------------------------------------------------------
module mbrc_checker
	import mbrc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        frame_end,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  out_channel,
	input logic [2:0]  frame_status,
	input logic signed [31:0] count_value
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_channel)
			&& $stable(frame_status) && $stable(count_value))
		else $error("stalled result changed");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a stalled result");

	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall && frame_end, 2))
		else $error("result without a frame-end transfer");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_status <= ST_BAD_CRC)
		else $error("frame status out of range");

endmodule

bind modbus_read_response_check mbrc_checker u_mbrc_checker (.*);
